### hdl/npcm_pkg.sv
// Shared types and constants for the nearest palette color mapper.
// No dependencies; every other file refers to this package by scoped names.
package npcm_pkg;

   localparam int CHAN_W = 8;                 // one color channel, alpha, index field
   localparam int DIST_W = 18;                // 3 * 255^2 fits in 18 bits
   localparam logic [CHAN_W-1:0] ALPHA_THR_RESET = 8'd128;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

### hdl/npcm_if.sv
// Valid/ready channel interfaces for the request, response and CSR write ports.
// Depends on npcm_pkg for field widths.
interface npcm_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [npcm_pkg::CHAN_W-1:0] entry_index;
   logic [npcm_pkg::CHAN_W-1:0] red;
   logic [npcm_pkg::CHAN_W-1:0] green;
   logic [npcm_pkg::CHAN_W-1:0] blue;
   logic [npcm_pkg::CHAN_W-1:0] alpha;

   modport source (output valid, operation, entry_index, red, green, blue, alpha,
                   input ready);
   modport sink   (input valid, operation, entry_index, red, green, blue, alpha,
                   output ready);
endinterface

interface npcm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [npcm_pkg::CHAN_W-1:0] color_index;
   logic                       is_transparent;

   modport source (output valid, color_index, is_transparent, input ready);
   modport sink   (input valid, color_index, is_transparent, output ready);
endinterface

interface npcm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [npcm_pkg::CHAN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### hdl/npcm_nearest.sv
// Distance and best-match tracker: one palette entry per cycle, squared RGB
// distance registered, then compared against the running best. Uses npcm_pkg.
module npcm_nearest #(
   parameter int IDX_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  npcm_pkg::rgb_type    pixel,
   input  logic                 ent_vld,
   input  logic [IDX_W-1:0]     ent_idx,
   input  npcm_pkg::rgb_type    ent_rgb,
   output logic                 busy,
   output logic [IDX_W-1:0]     best_idx
);

   logic                          dist_vld_ff;
   logic [IDX_W-1:0]              dist_idx_ff;
   logic [npcm_pkg::DIST_W-1:0]   dist_ff;
   logic [npcm_pkg::DIST_W-1:0]   dist_in;
   logic [npcm_pkg::DIST_W-1:0]   best_dist_ff;
   logic [IDX_W-1:0]              best_idx_ff;
   logic                          take_new;

   function automatic logic [2*npcm_pkg::CHAN_W-1:0] sq_diff(
      input logic [npcm_pkg::CHAN_W-1:0] a,
      input logic [npcm_pkg::CHAN_W-1:0] b
   );
      logic [npcm_pkg::CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (2*npcm_pkg::CHAN_W)'(d) * (2*npcm_pkg::CHAN_W)'(d);
   endfunction

   always_comb begin
      dist_in = npcm_pkg::DIST_W'(sq_diff(pixel.red,   ent_rgb.red))
              + npcm_pkg::DIST_W'(sq_diff(pixel.green, ent_rgb.green))
              + npcm_pkg::DIST_W'(sq_diff(pixel.blue,  ent_rgb.blue));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else begin
         dist_vld_ff <= ent_vld;
      end
      dist_idx_ff <= ent_idx;
      dist_ff     <= dist_in;
   end

   // entry 1 opens the search; afterwards only a strictly smaller distance wins
   assign take_new = dist_vld_ff &&
                     ((dist_idx_ff == IDX_W'(1)) || (dist_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take_new) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= dist_idx_ff;
      end
   end

   assign busy     = dist_vld_ff;
   assign best_idx = best_idx_ff;

endmodule

### hdl/nearest_palette_color_mapper.sv
// Pixel: the palette is scanned, entries 1..PALETTE_ENTRIES-1, through the registered
// read and the distance tracker, then the result is loaded into the output register.
// Transparent pixel: goes straight to the output register, no scan. Palette write: no result.
// The next request is taken once the result is in the output register.
// Reset (synchronous) clears the entry valid bits, so the palette reads as zero,
// and sets alpha_threshold to 128.
module nearest_palette_color_mapper #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   npcm_req_if.sink     req_ch,
   npcm_rsp_if.source   rsp_ch,
   npcm_csr_if.sink     csr_ch
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [npcm_pkg::CHAN_W-1:0]  thr_ff;
   npcm_pkg::rgb_type            pixel_ff;
   logic                         trans_ff;
   logic [IDX_W-1:0]             scan_idx_ff;

   npcm_pkg::rgb_type            mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]   ent_ok_ff;
   npcm_pkg::rgb_type            rd_data_ff;
   logic                         rd_ok_ff;
   logic                         rd_vld_ff;
   logic [IDX_W-1:0]             rd_idx_ff;
   npcm_pkg::rgb_type            ent_rgb;

   logic                         search_busy;
   logic [IDX_W-1:0]             best_idx;

   logic                         rsp_vld_ff;
   logic [npcm_pkg::CHAN_W-1:0]  rsp_idx_ff;
   logic                         rsp_trans_ff;

   logic req_xfer, wr_xfer, pix_xfer, below_thr, wr_in_range, rsp_load, scan_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign wr_xfer      = req_xfer && (req_ch.operation == npcm_pkg::OP_WRITE);
   assign pix_xfer     = req_xfer && (req_ch.operation == npcm_pkg::OP_PIXEL);
   assign below_thr    = req_ch.alpha < thr_ff;
   assign wr_in_range  = {1'b0, req_ch.entry_index} < 9'(PALETTE_ENTRIES);
   assign scan_last    = scan_idx_ff == IDX_W'(PALETTE_ENTRIES - 1);
   assign rsp_load     = (state_ff == ST_FINISH) && (!rsp_vld_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pix_xfer) begin
               state_in = below_thr ? ST_FINISH : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !search_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff   <= npcm_pkg::ALPHA_THR_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid && csr_ch.ready) begin
            thr_ff <= csr_ch.data;
         end
      end
   end

   // latch the pixel and start the scan at entry 1
   always_ff @(posedge clock) begin
      if (pix_xfer) begin
         pixel_ff    <= '{red: req_ch.red, green: req_ch.green, blue: req_ch.blue};
         trans_ff    <= below_thr;
         scan_idx_ff <= IDX_W'(1);
      end else if (state_ff == ST_SEARCH) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
   end

   // palette memory: write on an in-range palette transfer, read one entry per search cycle
   always_ff @(posedge clock) begin
      if (wr_xfer && wr_in_range) begin
         mem[req_ch.entry_index[IDX_W-1:0]] <=
            '{red: req_ch.red, green: req_ch.green, blue: req_ch.blue};
      end
      rd_data_ff <= mem[scan_idx_ff];
      rd_ok_ff   <= ent_ok_ff[scan_idx_ff];
      rd_idx_ff  <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ok_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_xfer && wr_in_range) begin
            ent_ok_ff[req_ch.entry_index[IDX_W-1:0]] <= 1'b1;
         end
         rd_vld_ff <= (state_ff == ST_SEARCH);
      end
   end

   // never-written entries read as zero through their cleared valid bit
   assign ent_rgb = rd_ok_ff ? rd_data_ff : '0;

   npcm_nearest #(
      .IDX_W (IDX_W)
   ) u_nearest (
      .clock    (clock),
      .reset    (reset),
      .pixel    (pixel_ff),
      .ent_vld  (rd_vld_ff),
      .ent_idx  (rd_idx_ff),
      .ent_rgb  (ent_rgb),
      .busy     (search_busy),
      .best_idx (best_idx)
   );

   // output register: hold until the response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff   <= trans_ff ? '0 : npcm_pkg::CHAN_W'(best_idx);
         rsp_trans_ff <= trans_ff;
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.color_index    = rsp_idx_ff;
   assign rsp_ch.is_transparent = rsp_trans_ff;

endmodule

### hdl/npcm_checker.sv
// Port-level checks for nearest_palette_color_mapper, attached by bind.
// Depends on npcm_pkg and the channel interfaces of the top level.
module npcm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [npcm_pkg::CHAN_W-1:0] rsp_color_index,
   input logic                        rsp_is_transparent
);

   // a waiting result stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_color_index) && $stable(rsp_is_transparent))
      else $error("response payload changed while stalled");

   a_trans_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_transparent |-> rsp_color_index == '0)
      else $error("transparent result with nonzero index");

   a_opaque_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_transparent |-> rsp_color_index != '0)
      else $error("opaque result selected entry zero");

   // no result can appear in the cycle right after a request transfer
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_color_index    (rsp_ch.color_index),
   .rsp_is_transparent (rsp_ch.is_transparent)
);
